[rtl/core/hsw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_pkg: shared types and constants of the hash set of words
// Sizes of the bucket table, request codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hsw_pkg;

  // Table geometry. The bucket hash in hsw_dp uses 2^8 = -1 (mod 257).
  localparam int BUCKETS = 257;
  localparam int WAYS    = 4;
  localparam int SLOTS   = BUCKETS * WAYS;

  localparam int WORD_W = 64;
  localparam int MODE_W = 3;
  localparam int CNT_W  = 11;
  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int BKT_W  = $clog2(BUCKETS + 1);
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int SLOT_W = $clog2(SLOTS);

  // Hash arithmetic widths.
  localparam int HSUM_W = 10;
  localparam int HT_W   = 12;
  localparam int HU_W   = 10;

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WALK_START = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WALK_NEXT  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic clr_start;
    logic clr_step;
    logic hash_lo;
    logic hash_hi;
    logic fill_rd_hash;
    logic fill_rd_walk;
    logic way_rst;
    logic way_rd;
    logic way_inc;
    logic add_wr;
    logic set_new;
    logic set_stored;
    logic set_full;
    logic walk_start;
    logic walk_next_bucket;
    logic walk_rd;
    logic walk_take;
    logic walk_end;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              clr_last;
    logic              way_lt_fill;
    logic              hit;
    logic              fill_full;
    logic              walk_at_end;
    logic              walk_found;
    logic              phase;
    logic              out_busy;
  } sts_t;

  // Word store address of one way of one bucket.
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [BIDX_W-1:0] b,
                                                  input logic [FILL_W-1:0] w);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(SLOT_W'(b) * SLOT_W'(WAYS));
    return SLOT_W'(base + SLOT_W'(w));
  endfunction

endpackage

[rtl/core/hsw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_if: request and result channels of the hash set of words
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface hsw_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsw_pkg::MODE_W-1:0] mode;
  logic [hsw_pkg::WORD_W-1:0] element;

  modport source(output valid, mode, element, input ready);
  modport sink(input valid, mode, element, output ready);
endinterface

interface hsw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       was_new;
  logic                       stored;
  logic                       bucket_full;
  logic [hsw_pkg::CNT_W-1:0]  member_count;
  logic [hsw_pkg::WORD_W-1:0] walk_word;
  logic                       walk_valid;
  logic                       walk_done;

  modport source(output valid, was_new, stored, bucket_full, member_count,
                 walk_word, walk_valid, walk_done, input ready);
  modport sink(input valid, was_new, stored, bucket_full, member_count,
               walk_word, walk_valid, walk_done, output ready);
endinterface

[rtl/core/hsw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/hsw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_dp: datapath of the hash set of words
// Request registers, bucket hash, fill and word memories, walk cursor,
// member count and the result register.
// ----------------------------------------------------------------------------
module hsw_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hsw_pkg::cmd_t              cmd,
  output hsw_pkg::sts_t              sts,
  input  logic [hsw_pkg::MODE_W-1:0] in_mode,
  input  logic [hsw_pkg::WORD_W-1:0] in_element,
  hsw_out_if.source                  out_ch
);

  // Request registers.
  logic [hsw_pkg::MODE_W-1:0] mode_r;
  logic [hsw_pkg::WORD_W-1:0] elem_r;

  // Hash stages.
  logic [hsw_pkg::HSUM_W-1:0] esum_r, osum_r;
  logic [hsw_pkg::BIDX_W-1:0] bkt_r;
  logic [hsw_pkg::HT_W-1:0]   hash_t;
  logic [hsw_pkg::HU_W-1:0]   hash_u;
  logic [hsw_pkg::BIDX_W-1:0] hash_b;

  // Control state.
  logic [hsw_pkg::FILL_W-1:0] way_r;
  logic [hsw_pkg::BIDX_W-1:0] clr_idx_r;
  logic [hsw_pkg::CNT_W-1:0]  cnt_r;
  logic [hsw_pkg::BKT_W-1:0]  wb_r;
  logic [hsw_pkg::FILL_W-1:0] ww_r;
  logic                       phase_r;

  // Result fields being built.
  logic                       new_r, stored_r, full_r, wvalid_r, wdone_r;
  logic [hsw_pkg::WORD_W-1:0] wword_r;

  // Result register.
  logic                       out_valid_r;
  logic                       o_new_r, o_stored_r, o_full_r, o_wvalid_r, o_wdone_r;
  logic [hsw_pkg::CNT_W-1:0]  o_cnt_r;
  logic [hsw_pkg::WORD_W-1:0] o_word_r;

  // Memory ports.
  logic                       fill_we, fill_re;
  logic [hsw_pkg::BIDX_W-1:0] fill_waddr, fill_raddr;
  logic [hsw_pkg::FILL_W-1:0] fill_wdata, fill_q;
  logic                       word_re;
  logic [hsw_pkg::SLOT_W-1:0] word_waddr, word_raddr;
  logic [hsw_pkg::WORD_W-1:0] word_q;

  // Second hash stage: reduce the alternating byte sum modulo 257.
  always_comb begin
    hash_t = hsw_pkg::HT_W'(hsw_pkg::HT_W'(esum_r) + hsw_pkg::HT_W'(4 * hsw_pkg::BUCKETS)
                            - hsw_pkg::HT_W'(osum_r));
    hash_u = hsw_pkg::HU_W'(hsw_pkg::HU_W'(hash_t[7:0]) + hsw_pkg::HU_W'(hsw_pkg::BUCKETS)
                            - hsw_pkg::HU_W'(hash_t[hsw_pkg::HT_W-1:8]));
    if (hash_u >= hsw_pkg::HU_W'(hsw_pkg::BUCKETS)) begin
      hash_b = hsw_pkg::BIDX_W'(hash_u - hsw_pkg::HU_W'(hsw_pkg::BUCKETS));
    end else begin
      hash_b = hsw_pkg::BIDX_W'(hash_u);
    end
  end

  // Memory addressing.
  always_comb begin
    fill_re    = cmd.fill_rd_hash | cmd.fill_rd_walk;
    fill_raddr = cmd.fill_rd_walk ? wb_r[hsw_pkg::BIDX_W-1:0] : bkt_r;
    fill_we    = cmd.clr_step | cmd.add_wr;
    fill_waddr = cmd.clr_step ? clr_idx_r : bkt_r;
    fill_wdata = cmd.clr_step ? '0 : hsw_pkg::FILL_W'(fill_q + 1'b1);
    word_re    = cmd.way_rd | cmd.walk_rd;
    word_raddr = cmd.walk_rd ? hsw_pkg::slot_addr(wb_r[hsw_pkg::BIDX_W-1:0], ww_r)
                             : hsw_pkg::slot_addr(bkt_r, way_r);
    word_waddr = hsw_pkg::slot_addr(bkt_r, fill_q);
  end

  hsw_ram #(.WIDTH(hsw_pkg::FILL_W), .DEPTH(hsw_pkg::BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (fill_raddr),
    .rdata (fill_q)
  );

  hsw_ram #(.WIDTH(hsw_pkg::WORD_W), .DEPTH(hsw_pkg::SLOTS)) u_word_ram (
    .clk   (clk),
    .we    (cmd.add_wr),
    .waddr (word_waddr),
    .wdata (elem_r),
    .re    (word_re),
    .raddr (word_raddr),
    .rdata (word_q)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_r <= in_mode;
      elem_r <= in_element;
    end
    if (cmd.hash_lo) begin
      esum_r <= hsw_pkg::HSUM_W'(elem_r[7:0]) + hsw_pkg::HSUM_W'(elem_r[23:16])
              + hsw_pkg::HSUM_W'(elem_r[39:32]) + hsw_pkg::HSUM_W'(elem_r[55:48]);
      osum_r <= hsw_pkg::HSUM_W'(elem_r[15:8]) + hsw_pkg::HSUM_W'(elem_r[31:24])
              + hsw_pkg::HSUM_W'(elem_r[47:40]) + hsw_pkg::HSUM_W'(elem_r[63:56]);
    end
    if (cmd.hash_hi) begin
      bkt_r <= hash_b;
    end
    if (cmd.load_req) begin
      wword_r <= '0;
    end else if (cmd.walk_take) begin
      wword_r <= word_q;
    end
    if (cmd.out_load) begin
      o_new_r    <= new_r;
      o_stored_r <= stored_r;
      o_full_r   <= full_r;
      o_wvalid_r <= wvalid_r;
      o_wdone_r  <= wdone_r;
      o_cnt_r    <= cnt_r;
      o_word_r   <= wword_r;
    end
  end

  // Control state: sweep index, count, cursor, flags and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_r       <= '0;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      wb_r        <= '0;
      ww_r        <= '0;
      phase_r     <= 1'b0;
      new_r       <= 1'b0;
      stored_r    <= 1'b0;
      full_r      <= 1'b0;
      wvalid_r    <= 1'b0;
      wdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        phase_r  <= 1'b0;
        new_r    <= 1'b0;
        stored_r <= 1'b0;
        full_r   <= 1'b0;
        wvalid_r <= 1'b0;
        wdone_r  <= 1'b0;
      end
      if (cmd.set_new) new_r <= 1'b1;
      if (cmd.set_stored) stored_r <= 1'b1;
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.way_rst) begin
        way_r <= '0;
      end else if (cmd.way_inc) begin
        way_r <= hsw_pkg::FILL_W'(way_r + 1'b1);
      end
      if (cmd.clr_start) begin
        clr_idx_r <= '0;
        cnt_r     <= '0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= hsw_pkg::BIDX_W'(clr_idx_r + 1'b1);
      end else if (cmd.add_wr) begin
        cnt_r <= hsw_pkg::CNT_W'(cnt_r + 1'b1);
      end
      if (cmd.clr_start || cmd.walk_start) begin
        wb_r <= '0;
        ww_r <= '0;
      end else if (cmd.walk_next_bucket) begin
        wb_r <= hsw_pkg::BKT_W'(wb_r + 1'b1);
        ww_r <= '0;
      end else if (cmd.walk_take) begin
        ww_r     <= hsw_pkg::FILL_W'(ww_r + 1'b1);
        phase_r  <= 1'b1;
        wvalid_r <= 1'b1;
      end else if (cmd.walk_end) begin
        ww_r    <= '0;
        wdone_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.mode        = mode_r;
    sts.clr_last    = (clr_idx_r == hsw_pkg::BIDX_W'(hsw_pkg::BUCKETS - 1));
    sts.way_lt_fill = (way_r < fill_q);
    sts.hit         = (word_q == elem_r);
    sts.fill_full   = (fill_q >= hsw_pkg::FILL_W'(hsw_pkg::WAYS));
    sts.walk_at_end = (wb_r == hsw_pkg::BKT_W'(hsw_pkg::BUCKETS));
    sts.walk_found  = (ww_r < fill_q);
    sts.phase       = phase_r;
    sts.out_busy    = out_valid_r & ~out_ch.ready;
  end

  // Result channel.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.was_new      = o_new_r;
  assign out_ch.stored       = o_stored_r;
  assign out_ch.bucket_full  = o_full_r;
  assign out_ch.member_count = o_cnt_r;
  assign out_ch.walk_word    = o_word_r;
  assign out_ch.walk_valid   = o_wvalid_r;
  assign out_ch.walk_done    = o_wdone_r;

endmodule

[rtl/core/hsw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_ctrl: controller of the hash set of words
// State machine that sequences the clearing sweep, bucket probes, adds and
// walk steps by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module hsw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hsw_pkg::sts_t sts,
  output hsw_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DEC   = 13'b0000000000100,
    S_CLR   = 13'b0000000001000,
    S_HASH  = 13'b0000000010000,
    S_FRD   = 13'b0000000100000,
    S_PROBE = 13'b0000001000000,
    S_CMP   = 13'b0000010000000,
    S_WSEEK = 13'b0000100000000,
    S_WCHK  = 13'b0001000000000,
    S_WGET  = 13'b0010000000000,
    S_WEND  = 13'b0100000000000,
    S_RESP  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.mode)
          hsw_pkg::MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
          hsw_pkg::MODE_ADD, hsw_pkg::MODE_QUERY: begin
            cmd.hash_lo = 1'b1;
            state_nxt   = S_HASH;
          end
          hsw_pkg::MODE_WALK_START: begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WSEEK;
          end
          hsw_pkg::MODE_WALK_NEXT: state_nxt = S_WSEEK;
          default: state_nxt = S_RESP;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_RESP;
      end
      S_HASH: begin
        cmd.hash_hi = 1'b1;
        state_nxt   = S_FRD;
      end
      S_FRD: begin
        cmd.fill_rd_hash = 1'b1;
        cmd.way_rst      = 1'b1;
        state_nxt        = S_PROBE;
      end
      S_PROBE: begin
        priority if (sts.way_lt_fill) begin
          cmd.way_rd = 1'b1;
          state_nxt  = S_CMP;
        end else if (sts.mode != hsw_pkg::MODE_ADD) begin
          cmd.set_new = 1'b1;
          state_nxt   = S_RESP;
        end else if (sts.fill_full) begin
          cmd.set_new  = 1'b1;
          cmd.set_full = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.set_new    = 1'b1;
          cmd.set_stored = 1'b1;
          cmd.add_wr     = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          state_nxt = S_RESP;
        end else begin
          cmd.way_inc = 1'b1;
          state_nxt   = S_PROBE;
        end
      end
      S_WSEEK: begin
        if (sts.walk_at_end) begin
          state_nxt = S_WEND;
        end else begin
          cmd.fill_rd_walk = 1'b1;
          state_nxt        = S_WCHK;
        end
      end
      S_WCHK: begin
        priority if (!sts.walk_found) begin
          cmd.walk_next_bucket = 1'b1;
          state_nxt            = S_WSEEK;
        end else if (sts.phase) begin
          state_nxt = S_RESP;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WGET;
        end
      end
      S_WGET: begin
        cmd.walk_take = 1'b1;
        state_nxt     = S_WSEEK;
      end
      S_WEND: begin
        cmd.walk_end = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/hash_set_of_words.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_of_words: set of 64-bit words in 257 buckets of 4 ways
// Add, query, walk and clear requests, one result per request.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload
//  in_ch    sink    mode, element
//  out_ch   source  was_new, stored, bucket_full, member_count,
//                   walk_word, walk_valid, walk_done
//
// One request at a time. An add or query probes the ways held in its bucket
// one after another through the single word memory read port, and stops at
// the way where the word is found.
// A walk reads the fill memory once for each bucket that it passes over.
// Clear resets the count and sweeps the fill memory one bucket per cycle.
// After reset a sweep clears the fill memory before ready rises.
// A stalled result waits in the output register while ready stays low.
// ----------------------------------------------------------------------------
module hash_set_of_words (
  input  logic      clk,
  input  logic      rst_n,
  hsw_in_if.sink    in_ch,
  hsw_out_if.source out_ch
);

  hsw_pkg::cmd_t cmd;
  hsw_pkg::sts_t sts;

  hsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_ch.mode),
    .in_element (in_ch.element),
    .out_ch     (out_ch)
  );

endmodule

[rtl/core/hsw_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsw_chk: port checker of the hash set of words
// Watches the request and result channels and flags broken rules.
// ----------------------------------------------------------------------------
module hsw_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       was_new,
  input logic                       stored,
  input logic                       bucket_full,
  input logic [hsw_pkg::CNT_W-1:0]  member_count,
  input logic                       walk_valid
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Requests are taken one at a time.
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // A stored word was new and its bucket was not full.
  a_stored_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stored |-> was_new && !bucket_full)
    else $error("stored with inconsistent flags");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> member_count <= hsw_pkg::CNT_W'(hsw_pkg::SLOTS))
    else $error("member count beyond capacity");

  // A walk result carries no add or query flags.
  a_walk_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && walk_valid |-> !was_new && !stored && !bucket_full)
    else $error("walk result with add flags");

endmodule

bind hash_set_of_words hsw_chk u_hsw_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .was_new      (out_ch.was_new),
  .stored       (out_ch.stored),
  .bucket_full  (out_ch.bucket_full),
  .member_count (out_ch.member_count),
  .walk_valid   (out_ch.walk_valid)
);
